@@ src/xml_entity_decoder_defines.svh @@
// Assertion helpers shared by the decoder modules.
`ifndef XML_ENTITY_DECODER_DEFINES_SVH
`define XML_ENTITY_DECODER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define XED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define XED_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/xed_pkg.sv @@
package xed_pkg;

  localparam int unsigned NameMaxDef    = 4;
  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned NumNames      = 6;
  localparam int unsigned LenW          = 4;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_HASH = 8'h23;

  // Entity names, first character in the low byte.
  localparam logic [NumNames-1:0][31:0] ENT_NAME = '{
    "touq",
    {16'h0000, "tg"},
    {16'h0000, "tl"},
    "sopa",
    {8'h00, "pma"},
    "psbn"
  };
  localparam logic [NumNames-1:0][LenW-1:0] ENT_LEN = '{
    4'd4, 4'd2, 4'd2, 4'd4, 4'd3, 4'd4
  };
  localparam logic [NumNames-1:0][7:0] ENT_CHAR = '{
    8'h22, 8'h3e, 8'h3c, 8'h27, 8'h26, 8'h20
  };

  typedef struct packed {
    logic       flush;     // emit '&' and the buffered name first
    logic       tail_vld;  // then one trailing character
    logic [7:0] tail;
    logic       last;      // request ends the stream
  } cmd_ctrl_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] ch;
  } lookup_t;

  function automatic logic is_name_char(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || (c == CH_HASH);
  endfunction

  function automatic lookup_t ent_lookup(input logic [31:0] nm, input logic [LenW-1:0] len);
    lookup_t    res;
    logic [31:0] mask;
    res = '0;
    for (int i = 0; i < NumNames; i++) begin
      mask = (ENT_LEN[i] == 4'd4) ? 32'hffff_ffff :
             (ENT_LEN[i] == 4'd3) ? 32'h00ff_ffff : 32'h0000_ffff;
      if (len == ENT_LEN[i] && ((nm & mask) == ENT_NAME[i])) begin
        res.hit = 1'b1;
        res.ch  = ENT_CHAR[i];
      end
    end
    return res;
  endfunction

endpackage

@@ src/xed_front.sv @@
`include "xml_entity_decoder_defines.svh"

module xed_front #(
  parameter int unsigned NAME_MAX = xed_pkg::NameMaxDef,
  localparam int unsigned CW = $clog2(NAME_MAX + 1),
  localparam int unsigned NW = $clog2(NAME_MAX)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [7:0]              in_byte_i,
  input  logic                    in_last_i,
  output logic                    push_o,
  output xed_pkg::cmd_ctrl_t      ctrl_o,
  output logic [CW-1:0]           cnt_o,
  output logic [NAME_MAX*8-1:0]   name_o
);

  logic            in_ent_q, in_ent_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [7:0]      name_q [NAME_MAX];
  logic            name_ch;
  logic            room;
  logic            store;
  xed_pkg::lookup_t lk;

  assign name_ch = xed_pkg::is_name_char(in_byte_i);
  assign room    = cnt_q < CW'(NAME_MAX);
  assign store   = accept_i && in_ent_q && name_ch && room;

  // Name snapshot including a character stored this cycle.
  always_comb begin
    for (int i = 0; i < NAME_MAX; i++) begin
      name_o[i*8 +: 8] = (store && cnt_q == CW'(i)) ? in_byte_i : name_q[i];
    end
  end

  assign lk = xed_pkg::ent_lookup(name_o[31:0], xed_pkg::LenW'(cnt_q));

  always_comb begin
    push_o          = 1'b0;
    ctrl_o          = '0;
    ctrl_o.last     = in_last_i;
    cnt_o           = cnt_q;
    in_ent_d        = in_ent_q;
    cnt_d           = cnt_q;
    if (accept_i) begin
      if (in_ent_q) begin
        if (name_ch) begin
          if (room) begin
            cnt_d = cnt_q + CW'(1);
            if (in_last_i) begin
              push_o       = 1'b1;
              ctrl_o.flush = 1'b1;
              cnt_o        = cnt_q + CW'(1);
              in_ent_d     = 1'b0;
            end
          end else begin
            push_o          = 1'b1;
            ctrl_o.flush    = 1'b1;
            ctrl_o.tail_vld = 1'b1;
            ctrl_o.tail     = in_byte_i;
            in_ent_d        = 1'b0;
          end
        end else if (in_byte_i == xed_pkg::CH_SEMI) begin
          push_o          = 1'b1;
          ctrl_o.tail_vld = 1'b1;
          if (lk.hit) begin
            ctrl_o.tail  = lk.ch;
          end else begin
            ctrl_o.flush = 1'b1;
            ctrl_o.tail  = in_byte_i;
          end
          in_ent_d = 1'b0;
        end else if (in_byte_i == xed_pkg::CH_AMP) begin
          // old name goes out, a fresh entity opens unless this is the last byte
          push_o       = 1'b1;
          ctrl_o.flush = 1'b1;
          cnt_d        = '0;
          if (in_last_i) begin
            ctrl_o.tail_vld = 1'b1;
            ctrl_o.tail     = in_byte_i;
            in_ent_d        = 1'b0;
          end
        end else begin
          push_o          = 1'b1;
          ctrl_o.flush    = 1'b1;
          ctrl_o.tail_vld = 1'b1;
          ctrl_o.tail     = in_byte_i;
          in_ent_d        = 1'b0;
        end
      end else if (in_byte_i == xed_pkg::CH_AMP && !in_last_i) begin
        in_ent_d = 1'b1;
        cnt_d    = '0;
      end else begin
        push_o          = 1'b1;
        ctrl_o.tail_vld = 1'b1;
        ctrl_o.tail     = in_byte_i;
      end
      if (!in_ent_d) begin
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ent_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      in_ent_q <= in_ent_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      name_q[cnt_q[NW-1:0]] <= in_byte_i;
    end
  end

  `XED_ASSERT(a_idle_no_name, !in_ent_q |-> cnt_q == '0, "name count set outside an entity")
  `XED_ASSERT(a_cnt_bound, cnt_q <= CW'(NAME_MAX), "name count above limit")
  `XED_ASSERT(a_silent_only_in_name, accept_i && !push_o |=> in_ent_q,
              "silent request left the entity closed")

endmodule

@@ src/xed_queue.sv @@
`include "xml_entity_decoder_defines.svh"

module xed_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = xed_pkg::QueueDepthDef,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNTW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             vld_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;

  assign full_o = cnt_q == CNTW'(DEPTH);
  assign vld_o  = cnt_q != '0;
  assign data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `XED_ASSERT(a_no_overflow, push_i |-> !full_o, "push into a full queue")
  `XED_ASSERT(a_no_underflow, pop_i |-> vld_o, "pop from an empty queue")
  // an edge seen in reset leaves the queue empty at the next edge
  `XED_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> cnt_q == '0, "queue not empty after reset")

endmodule

@@ src/xed_back.sv @@
`include "xml_entity_decoder_defines.svh"

module xed_back #(
  parameter int unsigned NAME_MAX = xed_pkg::NameMaxDef,
  localparam int unsigned CW = $clog2(NAME_MAX + 1),
  localparam int unsigned NW = $clog2(NAME_MAX),
  localparam int unsigned IW = $clog2(NAME_MAX + 2)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_vld_i,
  input  xed_pkg::cmd_ctrl_t    ctrl_i,
  input  logic [CW-1:0]         cnt_i,
  input  logic [NAME_MAX*8-1:0] name_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            out_byte_o,
  output logic                  run_last_o,
  output logic                  stream_last_o
);

  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] last_idx;
  logic [IW-1:0] idx_m1;
  logic          emit;
  logic          el_last;
  logic [7:0]    el_byte;
  logic          out_valid_q;
  logic [7:0]    out_byte_q;
  logic          run_last_q, stream_last_q;

  // sequence: '&', name[0..cnt-1] when flushing, then the tail character if tail_vld is set
  assign last_idx = ctrl_i.flush ? (IW'(cnt_i) + IW'(ctrl_i.tail_vld)) : '0;
  assign idx_m1   = idx_q - IW'(1);
  assign el_last  = idx_q == last_idx;
  assign emit     = head_vld_i && (!out_valid_q || out_ready_i);
  assign pop_o    = emit && el_last;

  always_comb begin
    if (ctrl_i.flush && idx_q == '0) begin
      el_byte = xed_pkg::CH_AMP;
    end else if (ctrl_i.flush && idx_q <= IW'(cnt_i)) begin
      el_byte = name_i[idx_m1[NW-1:0]*8 +: 8];
    end else begin
      el_byte = ctrl_i.tail;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (pop_o) begin
      idx_d = '0;
    end else if (emit) begin
      idx_d = idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q    <= el_byte;
      run_last_q    <= el_last;
      stream_last_q <= el_last && ctrl_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign run_last_o    = run_last_q;
  assign stream_last_o = stream_last_q;

  `XED_ASSERT(a_idx_in_range, head_vld_i |-> idx_q <= last_idx, "element index past request end")
  `XED_ASSERT(a_idx_idle, !head_vld_i |-> idx_q == '0, "element index set with no request")
  `XED_ASSERT(a_stream_end, out_valid_q && stream_last_q |-> run_last_q,
              "stream end on a non-final element")

endmodule

@@ src/xml_entity_decoder.sv @@
// XML entity decoder: bytes in, decoded bytes out, valid/ready on both sides.
// Input: in_byte_i with in_last_i marking the final stream byte. One byte is
// accepted per cycle while the request queue has room.
// Output: out_byte_o per result, run_last_o on the last result of one input
// byte, stream_last_o on the last result of the stream.
// The front end tracks the open entity and its buffered name and pushes one
// request per result-producing byte into a small queue; the back end expands
// each request into output bytes through an output register, one per cycle
// while the receiver is ready. An input byte reaches the output through the
// request queue and the output register. Throughput: 1 input byte per cycle
// while the receiver is ready and each byte yields one result; a flush of '&'
// plus n buffered name chars plus the ending byte gives up to NAME_MAX + 2
// output bytes, and the front end keeps taking input until the queue is full.
// A '&' outside an entity, or a buffered name char, yields no result unless it is the last byte.
// Reset clears the entity state, the queue and the output register; no
// result is pending after reset. When the receiver holds out_ready_i low the
// output register holds, the queue fills and in_ready_o drops.
module xml_entity_decoder #(
  parameter int unsigned NAME_MAX    = xed_pkg::NameMaxDef,
  parameter int unsigned QUEUE_DEPTH = xed_pkg::QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       stream_last_o
);

  localparam int unsigned CW = $clog2(NAME_MAX + 1);
  localparam int unsigned NB = NAME_MAX * 8;
  localparam int unsigned QW = $bits(xed_pkg::cmd_ctrl_t) + CW + NB;

  logic               accept;
  logic               push, full, pop, head_vld;
  xed_pkg::cmd_ctrl_t f_ctrl, b_ctrl;
  logic [CW-1:0]      f_cnt, b_cnt;
  logic [NB-1:0]      f_name, b_name;
  logic [QW-1:0]      q_wdata, q_rdata;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  xed_front #(
    .NAME_MAX (NAME_MAX)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .push_o    (push),
    .ctrl_o    (f_ctrl),
    .cnt_o     (f_cnt),
    .name_o    (f_name)
  );

  assign q_wdata = {f_ctrl, f_cnt, f_name};
  assign {b_ctrl, b_cnt, b_name} = q_rdata;

  xed_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_wdata),
    .full_o (full),
    .pop_i  (pop),
    .vld_o  (head_vld),
    .data_o (q_rdata)
  );

  xed_back #(
    .NAME_MAX (NAME_MAX)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_vld_i    (head_vld),
    .ctrl_i        (b_ctrl),
    .cnt_i         (b_cnt),
    .name_i        (b_name),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .stream_last_o (stream_last_o)
  );

endmodule
